/* sv/fpd_pkg.sv */
// fpd_pkg: shared types and constants of the flux pulse digital pll
// used by flux_pulse_dpll_top and fpd_divider; depends on nothing else
package fpd_pkg;

    // parameter defaults
    localparam int TICK_BITS_DEF = 16;
    localparam int MAX_CELLS_DEF = 4;

    // fixed field widths
    localparam int REG_W       = 16;  // window, pivot, gain registers
    localparam int MAXERR_W    = 24;  // sync loss limit register
    localparam int EST_W       = 20;  // bitcell estimate, sixteenths of a tick
    localparam int FRAC_W      = 4;   // sixteenths
    localparam int PE_OUT_W    = 23;  // reported phase error
    localparam int CNT_W       = 32;  // saturating event counters
    localparam int CELLS_OUT_W = 3;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int PE_OUT_MAX = 4194303;
    localparam int PE_OUT_MIN = -4194304;

    // register reset values
    localparam logic [REG_W-1:0]    WMIN_RST   = 16'd44;
    localparam logic [REG_W-1:0]    WMAX_RST   = 16'd52;
    localparam logic [REG_W-1:0]    PIVOT_RST  = 16'd48;
    localparam logic [REG_W-1:0]    SNUM_RST   = 16'd16;
    localparam logic [REG_W-1:0]    SDEN_RST   = 16'd16;
    localparam logic [REG_W-1:0]    FNUM_RST   = 16'd32;
    localparam logic [REG_W-1:0]    FDEN_RST   = 16'd32;
    localparam logic [MAXERR_W-1:0] MAXERR_RST = 24'd192;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WMIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WMAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIVOT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SNUM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SDEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FNUM   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FDEN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXERR = 3'd7;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_PULSE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SOFT  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CELLS,
        S_PHASE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_CLAMP,
        S_FIN
    } state_t;

    // handshake between sequencer and divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
    } div_sts_t;

endpackage

/* sv/fpd_divider.sv */
// fpd_divider: restoring unsigned divider, one quotient bit per cycle
// depends on fpd_pkg for the control and status structs
module fpd_divider #(
    parameter int DVD_W = 38,
    parameter int DSR_W = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fpd_pkg::div_ctl_t   ctl,
    input  logic [DVD_W-1:0]    dividend,
    input  logic [DSR_W-1:0]    divisor,
    output fpd_pkg::div_sts_t   sts,
    output logic [DVD_W-1:0]    quotient
);
    import fpd_pkg::*;

    localparam int CNT_BITS = $clog2(DVD_W + 1);

    logic                busy_reg, busy_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DSR_W-1:0]    rem_reg, rem_next;
    logic [DSR_W-1:0]    dsr_reg, dsr_next;
    logic [DVD_W-1:0]    quo_reg, quo_next;

    logic [DSR_W:0] shifted;
    logic [DSR_W:0] diff;
    logic           fits;

    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DVD_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            rem_next  = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign sts.busy = busy_reg;
    assign quotient = quo_reg;

endmodule

/* sv/flux_pulse_dpll_top.sv */
// flux_pulse_dpll_top: digital pll turning floppy flux intervals into bitcell counts
// depends on fpd_pkg and fpd_divider
//
//  channel  direction  handshake           payload
//  in       input      in_valid/in_stall   kind, pulse_ticks
//  out      output     out_valid/out_stall cells, pulse_fault, range_error, sync_loss,
//                                          phase_offset, bitcell_estimate,
//                                          error_count, sync_loss_count
//  cfg      input      cfg_we              cfg_index, cfg_data
//
// one item at a time: in_stall is high from acceptance until the result is loaded
// from acceptance to the output register load: reset items, unknown kinds and
//   rejected pulses go straight to the final state, pulses below window_min pass
//   the phase state, retuned pulses step through the cells, phase, mul, add, div
//   and clamp states, the bit-serial divider doing the gain ratio; then back to idle
// rst_n clears the sequencer and counters at once, sets the estimate to sixteen times
//   the default pivot and loads register defaults
// a stalled result sits in the output register; the next item is accepted meanwhile and
//   waits in the final state until the output register frees up
module flux_pulse_dpll_top #(
    parameter int TICK_BITS = fpd_pkg::TICK_BITS_DEF,
    parameter int MAX_CELLS = fpd_pkg::MAX_CELLS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fpd_pkg::KIND_W-1:0]        kind,
    input  logic [TICK_BITS-1:0]              pulse_ticks,
    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fpd_pkg::CELLS_OUT_W-1:0]   cells,
    output logic                              pulse_fault,
    output logic                              range_error,
    output logic                              sync_loss,
    output logic signed [fpd_pkg::PE_OUT_W-1:0] phase_offset,
    output logic [fpd_pkg::EST_W-1:0]         bitcell_estimate,
    output logic [fpd_pkg::CNT_W-1:0]         error_count,
    output logic [fpd_pkg::CNT_W-1:0]         sync_loss_count,
    // register writes
    input  logic                              cfg_we,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpd_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fpd_pkg::*;

    // derived widths
    localparam int CELL_W  = $clog2(MAX_CELLS + 1);
    localparam int ACT_W   = TICK_BITS + FRAC_W;           // pulse in sixteenths
    localparam int PROD_W  = EST_W + CELL_W;               // cells times estimate
    localparam int TRIAL_W = PROD_W + 1;
    localparam int SUM_W   = (ACT_W > TRIAL_W ? ACT_W : TRIAL_W) + 1;
    localparam int PE_W    = SUM_W + 1;                    // raw phase error, signed
    localparam int SYNC_W  = (PE_W > MAXERR_W + 1 ? PE_W : MAXERR_W + 1);
    localparam int RNG_W   = (TICK_BITS > REG_W + 2 ? TICK_BITS : REG_W + 2);
    localparam int MUL_W   = EST_W + REG_W;
    localparam int DVD_W   = (MUL_W > PE_W ? MUL_W : PE_W) + 2;

    localparam logic signed [PE_W-1:0] PE_HI = PE_W'(PE_OUT_MAX);
    localparam logic signed [PE_W-1:0] PE_LO = PE_W'(PE_OUT_MIN);

    // configuration registers
    logic [REG_W-1:0]    wmin_reg, wmax_reg, pivot_reg;
    logic [REG_W-1:0]    snum_reg, sden_reg, fnum_reg, fden_reg;
    logic [MAXERR_W-1:0] maxerr_reg;

    // loop state
    state_t                     state_reg, state_next;
    logic [EST_W-1:0]           est_reg, est_next;
    logic signed [PE_OUT_W-1:0] last_pe_reg, last_pe_next;
    logic [CNT_W-1:0]           rng_cnt_reg, rng_cnt_next;
    logic [CNT_W-1:0]           sync_cnt_reg, sync_cnt_next;

    // per-item working registers
    logic [ACT_W-1:0]           actual_reg, actual_next;
    logic [EST_W-1:0]           div_reg, div_next;
    logic [CELL_W-1:0]          cells_reg, cells_next;
    logic [PROD_W-1:0]          prod_reg, prod_next;
    logic signed [PE_W-1:0]     pe_reg, pe_next;
    logic [MUL_W-1:0]           mul_reg, mul_next;
    logic [REG_W-1:0]           den_reg, den_next;
    logic                       neg_reg, neg_next;
    logic                       rng_reg, rng_next;
    logic                       sync_reg, sync_next;
    logic signed [PE_OUT_W-1:0] pe_out_reg, pe_out_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [CELLS_OUT_W-1:0]     cells_o_reg, cells_o_next;
    logic                       rng_o_reg, rng_o_next;
    logic                       sync_o_reg, sync_o_next;
    logic signed [PE_OUT_W-1:0] pe_o_reg, pe_o_next;
    logic [EST_W-1:0]           est_o_reg, est_o_next;
    logic [CNT_W-1:0]           rng_cnt_o_reg, rng_cnt_o_next;
    logic [CNT_W-1:0]           sync_cnt_o_reg, sync_cnt_o_next;

    // sequencer outputs
    logic     in_take;
    logic     out_load;
    div_ctl_t div_ctl;
    div_sts_t div_sts;

    // divider
    logic [DVD_W-1:0] div_dividend;
    logic [DVD_W-1:0] div_quotient;

    // combinational helpers
    logic [RNG_W-1:0]       pulse_x, wmin_half_x, wmax_3x, wmin_x;
    logic                   out_of_range;
    logic [EST_W-1:0]       pivot16, wmin16, wmax16, cell_div;
    logic [SUM_W-1:0]       target, trial_x;
    logic [TRIAL_W-1:0]     trial;
    logic [PROD_W-1:0]      prod_used;
    logic signed [PE_W-1:0] pe_now;
    logic signed [SYNC_W-1:0] pe_sx, me_sx;
    logic                   sync_now;
    logic signed [PE_OUT_W-1:0] pe_sat;
    logic signed [DVD_W-1:0] dvd_s;
    logic                   below, above;
    logic [EST_W-1:0]       est_clamped;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wmin_reg   <= WMIN_RST;
            wmax_reg   <= WMAX_RST;
            pivot_reg  <= PIVOT_RST;
            snum_reg   <= SNUM_RST;
            sden_reg   <= SDEN_RST;
            fnum_reg   <= FNUM_RST;
            fden_reg   <= FDEN_RST;
            maxerr_reg <= MAXERR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WMIN:   wmin_reg   <= cfg_data[REG_W-1:0];
                CFG_WMAX:   wmax_reg   <= cfg_data[REG_W-1:0];
                CFG_PIVOT:  pivot_reg  <= cfg_data[REG_W-1:0];
                CFG_SNUM:   snum_reg   <= cfg_data[REG_W-1:0];
                CFG_SDEN:   sden_reg   <= cfg_data[REG_W-1:0];
                CFG_FNUM:   fnum_reg   <= cfg_data[REG_W-1:0];
                CFG_FDEN:   fden_reg   <= cfg_data[REG_W-1:0];
                CFG_MAXERR: maxerr_reg <= cfg_data[MAXERR_W-1:0];
                default:    ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // combinational helpers
    // ---------------------------------------------------------------
    // accept window is half of window_min up to three times window_max
    assign pulse_x      = RNG_W'(pulse_ticks);
    assign wmin_x       = RNG_W'(wmin_reg);
    assign wmin_half_x  = RNG_W'(wmin_reg >> 1);
    assign wmax_3x      = RNG_W'(wmax_reg) + RNG_W'({wmax_reg, 1'b0});
    assign out_of_range = (pulse_x < wmin_half_x) || (pulse_x > wmax_3x);

    assign pivot16 = {pivot_reg, {FRAC_W{1'b0}}};
    assign wmin16  = {wmin_reg, {FRAC_W{1'b0}}};
    assign wmax16  = {wmax_reg, {FRAC_W{1'b0}}};

    // rounding divisor: estimate, else nominal cell, else one
    always_comb
    begin
        if (est_reg != '0)
            cell_div = est_reg;
        else if (pivot_reg != '0)
            cell_div = pivot16;
        else
            cell_div = EST_W'(1);
    end

    // cells >= k while pulse + half a cell reaches k cells
    assign target  = SUM_W'(actual_reg) + SUM_W'(div_reg >> 1);
    assign trial   = TRIAL_W'(prod_reg) + TRIAL_W'(div_reg);
    assign trial_x = SUM_W'(trial);

    // a zero estimate contributes nothing to the expected position
    assign prod_used = (est_reg == '0) ? '0 : prod_reg;
    assign pe_now    = $signed(PE_W'(actual_reg)) - $signed(PE_W'(prod_used));

    assign pe_sx    = SYNC_W'(pe_now);
    assign me_sx    = $signed(SYNC_W'(maxerr_reg));
    assign sync_now = (pe_sx > me_sx) || (pe_sx < -me_sx);

    always_comb
    begin
        if (pe_now > PE_HI)
            pe_sat = PE_OUT_W'(PE_HI);
        else if (pe_now < PE_LO)
            pe_sat = PE_OUT_W'(PE_LO);
        else
            pe_sat = pe_now[PE_OUT_W-1:0];
    end

    // retune dividend: estimate times gain numerator plus phase error
    assign dvd_s        = $signed(DVD_W'(mul_reg)) + DVD_W'(pe_reg);
    assign div_dividend = dvd_s[DVD_W-1] ? DVD_W'(-dvd_s) : DVD_W'(dvd_s);

    // clamp low first, low wins
    assign below = (neg_reg && (div_quotient != '0)) || (div_quotient < DVD_W'(wmin16));
    assign above = !below && (div_quotient > DVD_W'(wmax16));

    always_comb
    begin
        if (above)
            est_clamped = wmax16;
        else if (below)
            est_clamped = (wmin16 > wmax16) ? wmax16 : wmin16;
        else
            est_clamped = div_quotient[EST_W-1:0];
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_PULSE && !out_of_range)
                        state_next = (pulse_x >= wmin_x) ? S_CELLS : S_PHASE;
                    else
                        state_next = S_FIN;
                end
            end
            S_CELLS:
            begin
                if (!((cells_reg < CELL_W'(MAX_CELLS)) && (target >= trial_x)))
                    state_next = S_PHASE;
            end
            S_PHASE: state_next = (cells_reg != '0) ? S_MUL : S_FIN;
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_DIV;
            S_DIV:
            begin
                if (!div_sts.busy)
                    state_next = S_CLAMP;
            end
            S_CLAMP: state_next = S_FIN;
            S_FIN:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer: control outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_stall      = (state_reg != S_IDLE);
        in_take       = in_valid && (state_reg == S_IDLE);
        div_ctl.start = (state_reg == S_ADD);
        out_load      = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    end

    // ---------------------------------------------------------------
    // datapath next values
    // ---------------------------------------------------------------
    always_comb
    begin
        est_next      = est_reg;
        last_pe_next  = last_pe_reg;
        rng_cnt_next  = rng_cnt_reg;
        sync_cnt_next = sync_cnt_reg;
        actual_next   = actual_reg;
        div_next      = div_reg;
        cells_next    = cells_reg;
        prod_next     = prod_reg;
        pe_next       = pe_reg;
        mul_next      = mul_reg;
        den_next      = den_reg;
        neg_next      = neg_reg;
        rng_next      = rng_reg;
        sync_next     = sync_reg;
        pe_out_next   = pe_out_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    rng_next    = 1'b0;
                    sync_next   = 1'b0;
                    cells_next  = '0;
                    pe_out_next = '0;
                    case (kind)
                        KIND_FULL:
                        begin
                            est_next      = pivot16;
                            last_pe_next  = '0;
                            rng_cnt_next  = '0;
                            sync_cnt_next = '0;
                        end
                        KIND_SOFT:
                            last_pe_next = '0;
                        KIND_PULSE:
                        begin
                            if (out_of_range)
                            begin
                                rng_next = 1'b1;
                                if (rng_cnt_reg != '1)
                                    rng_cnt_next = rng_cnt_reg + 1'b1;
                            end
                            else
                            begin
                                actual_next = {pulse_ticks, {FRAC_W{1'b0}}};
                                div_next    = cell_div;
                                if (pulse_x >= wmin_x)
                                begin
                                    cells_next = CELL_W'(1);
                                    prod_next  = PROD_W'(cell_div);
                                end
                                else
                                    prod_next = '0;
                            end
                        end
                        default:
                            pe_out_next = last_pe_reg;  // unknown kind reports state
                    endcase
                end
            end
            S_CELLS:
            begin
                if ((cells_reg < CELL_W'(MAX_CELLS)) && (target >= trial_x))
                begin
                    cells_next = cells_reg + 1'b1;
                    prod_next  = trial[PROD_W-1:0];
                end
            end
            S_PHASE:
            begin
                pe_next      = pe_now;
                pe_out_next  = pe_sat;
                last_pe_next = pe_sat;
                sync_next    = sync_now;
                if (sync_now && (sync_cnt_reg != '1))
                    sync_cnt_next = sync_cnt_reg + 1'b1;
            end
            S_MUL:
            begin
                // early pulse takes the slow gain, late pulse the fast one
                if (pe_reg[PE_W-1])
                begin
                    mul_next = MUL_W'(est_reg) * MUL_W'(snum_reg);
                    den_next = (sden_reg == '0) ? REG_W'(1) : sden_reg;
                end
                else
                begin
                    mul_next = MUL_W'(est_reg) * MUL_W'(fnum_reg);
                    den_next = (fden_reg == '0) ? REG_W'(1) : fden_reg;
                end
            end
            S_ADD:
                neg_next = dvd_s[DVD_W-1];
            S_CLAMP:
                est_next = est_clamped;
            default: ;
        endcase
    end

    // output register: hold while stalled
    always_comb
    begin
        out_valid_next  = out_load || (out_valid_reg && out_stall);
        cells_o_next    = cells_o_reg;
        rng_o_next      = rng_o_reg;
        sync_o_next     = sync_o_reg;
        pe_o_next       = pe_o_reg;
        est_o_next      = est_o_reg;
        rng_cnt_o_next  = rng_cnt_o_reg;
        sync_cnt_o_next = sync_cnt_o_reg;
        if (out_load)
        begin
            cells_o_next    = CELLS_OUT_W'(cells_reg);
            rng_o_next      = rng_reg;
            sync_o_next     = sync_reg;
            pe_o_next       = pe_out_reg;
            est_o_next      = est_reg;
            rng_cnt_o_next  = rng_cnt_reg;
            sync_cnt_o_next = sync_cnt_reg;
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            est_reg       <= {PIVOT_RST, {FRAC_W{1'b0}}};
            last_pe_reg   <= '0;
            rng_cnt_reg   <= '0;
            sync_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            est_reg       <= est_next;
            last_pe_reg   <= last_pe_next;
            rng_cnt_reg   <= rng_cnt_next;
            sync_cnt_reg  <= sync_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        actual_reg     <= actual_next;
        div_reg        <= div_next;
        cells_reg      <= cells_next;
        prod_reg       <= prod_next;
        pe_reg         <= pe_next;
        mul_reg        <= mul_next;
        den_reg        <= den_next;
        neg_reg        <= neg_next;
        rng_reg        <= rng_next;
        sync_reg       <= sync_next;
        pe_out_reg     <= pe_out_next;
        cells_o_reg    <= cells_o_next;
        rng_o_reg      <= rng_o_next;
        sync_o_reg     <= sync_o_next;
        pe_o_reg       <= pe_o_next;
        est_o_reg      <= est_o_next;
        rng_cnt_o_reg  <= rng_cnt_o_next;
        sync_cnt_o_reg <= sync_cnt_o_next;
    end

    // gain ratio divider, one quotient bit per cycle
    fpd_divider #(
        .DVD_W (DVD_W),
        .DSR_W (REG_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    // ports
    assign out_valid        = out_valid_reg;
    assign cells            = cells_o_reg;
    assign pulse_fault      = rng_o_reg || sync_o_reg;
    assign range_error      = rng_o_reg;
    assign sync_loss        = sync_o_reg;
    assign phase_offset     = pe_o_reg;
    assign bitcell_estimate = est_o_reg;
    assign error_count      = rng_cnt_o_reg;
    assign sync_loss_count  = sync_cnt_o_reg;

`ifndef NO_ASSERTIONS
    // an accepted item always leaves idle
    a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start the sequencer");

    // divider only runs while the sequencer waits for it
    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.busy |-> (state_reg == S_DIV))
        else $error("divider busy outside the divide state");

    // a rejected pulse spans no cells and is no sync loss
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rng_o_reg) |-> ((cells_o_reg == '0) && !sync_o_reg))
        else $error("rejected pulse reported cells or sync loss");

    // retuned cell count never exceeds the limit
    a_cells_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PHASE) |-> (cells_reg <= CELL_W'(MAX_CELLS)))
        else $error("cell count above the limit");
`endif

endmodule
